// ===== sv/achs_pkg.sv =====
// Shared types and constants for the address coverage hash set.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package achs_pkg;

   localparam int TABLE_BITS  = 12;
   localparam int MAX_PROBES  = 16;
   localparam int TABLE_SIZE  = 1 << TABLE_BITS;
   localparam int ADDR_WIDTH  = 32;
   localparam int COUNT_BITS  = 13;
   localparam int COUNT_FIELD_MAX = (1 << COUNT_BITS) - 1;
   localparam int COUNT_CAP   = (TABLE_SIZE < COUNT_FIELD_MAX) ? TABLE_SIZE : COUNT_FIELD_MAX;
   localparam int PROBE_BITS  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [ADDR_WIDTH-1:0] address;
   } req_type;

   typedef struct packed {
      logic                  is_new;
      logic                  dropped;
      logic [COUNT_BITS-1:0] distinct_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PROBE,
      ST_WIPE,
      ST_WIPE_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_insert;
      logic probe_next;
      logic finish_insert;
      logic wipe_start;
      logic sweep_step;
      logic finish_clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic hit;
      logic last_probe;
      logic out_free;
      logic sweep_last;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/achs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the slot table of the hash set.
`default_nettype none

module achs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/achs_ctrl.sv =====
// Controller state machine of the hash set: clearing sweeps, probing, result hand-off.
// Depends on achs_pkg for the state, command and status types.
`default_nettype none

module achs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_kind,
   output logic                   req_ready,
   input  wire achs_pkg::sts_type sts,
   output achs_pkg::cmd_type      cmd
);

   achs_pkg::state_type state_ff;
   achs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= achs_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         achs_pkg::ST_INIT: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = achs_pkg::ST_IDLE;
            end
         end
         achs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == achs_pkg::KIND_CLEAR) begin
                  cmd.wipe_start = 1'b1;
                  state_in       = achs_pkg::ST_WIPE;
               end else begin
                  cmd.take_insert = 1'b1;
                  state_in        = achs_pkg::ST_PROBE;
               end
            end
         end
         achs_pkg::ST_PROBE: begin
            // An empty slot wins over a match, so address zero always lands as new.
            if (sts.empty || sts.hit || sts.last_probe) begin
               if (sts.out_free) begin
                  cmd.finish_insert = 1'b1;
                  state_in          = achs_pkg::ST_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         achs_pkg::ST_WIPE: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = achs_pkg::ST_WIPE_DONE;
            end
         end
         achs_pkg::ST_WIPE_DONE: begin
            if (sts.out_free) begin
               cmd.finish_clear = 1'b1;
               state_in         = achs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = achs_pkg::ST_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/achs_datapath.sv =====
// Datapath of the hash set: slot memory, probe pointer, distinct count and result register.
// Depends on achs_pkg and instantiates achs_ram.
`default_nettype none

module achs_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire achs_pkg::req_type req_data,
   input  wire achs_pkg::cmd_type cmd,
   output achs_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output achs_pkg::rsp_type      rsp_data
);

   logic [achs_pkg::ADDR_WIDTH-1:0] addr_ff;
   logic [achs_pkg::TABLE_BITS-1:0] slot_ff;
   logic [achs_pkg::TABLE_BITS-1:0] slot_in;
   logic [achs_pkg::PROBE_BITS-1:0] probe_ff;
   logic [achs_pkg::TABLE_BITS-1:0] sweep_ff;
   logic [achs_pkg::COUNT_BITS-1:0] count_ff;
   logic [achs_pkg::COUNT_BITS-1:0] count_in;
   logic                            rsp_valid_ff;
   achs_pkg::rsp_type               rsp_data_ff;

   logic                            ram_wr_en;
   logic [achs_pkg::TABLE_BITS-1:0] ram_wr_addr;
   logic [achs_pkg::ADDR_WIDTH-1:0] ram_wr_data;
   logic                            ram_rd_en;
   logic [achs_pkg::TABLE_BITS-1:0] ram_rd_addr;
   logic [achs_pkg::ADDR_WIDTH-1:0] ram_rd_data;

   achs_ram #(
      .WIDTH(achs_pkg::ADDR_WIDTH),
      .DEPTH(achs_pkg::TABLE_SIZE)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Home slot on a new insert, otherwise the next slot with wraparound.
   assign slot_in = cmd.take_insert ? req_data.address[achs_pkg::TABLE_BITS:1]
                                    : slot_ff + 1'b1;

   assign ram_rd_en   = cmd.take_insert || cmd.probe_next;
   assign ram_rd_addr = slot_in;

   assign ram_wr_en   = cmd.sweep_step || (cmd.finish_insert && sts.empty);
   assign ram_wr_addr = cmd.sweep_step ? sweep_ff : slot_ff;
   assign ram_wr_data = cmd.sweep_step ? '0 : addr_ff;

   assign count_in = (count_ff < achs_pkg::COUNT_BITS'(achs_pkg::COUNT_CAP))
                     ? count_ff + 1'b1 : count_ff;

   assign sts.empty      = (ram_rd_data == '0);
   assign sts.hit        = (ram_rd_data == addr_ff);
   assign sts.last_probe = (probe_ff == achs_pkg::PROBE_BITS'(achs_pkg::MAX_PROBES - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.sweep_last = (sweep_ff == '1);

   always_ff @(posedge clock) begin
      if (cmd.take_insert) begin
         addr_ff  <= req_data.address;
         probe_ff <= '0;
      end else if (cmd.probe_next) begin
         probe_ff <= probe_ff + 1'b1;
      end
      if (ram_rd_en) begin
         slot_ff <= slot_in;
      end
      if (cmd.finish_insert) begin
         rsp_data_ff.is_new         <= sts.empty;
         rsp_data_ff.dropped        <= !sts.empty && !sts.hit;
         rsp_data_ff.distinct_count <= sts.empty ? count_in : count_ff;
      end else if (cmd.finish_clear) begin
         rsp_data_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wipe_start) begin
            sweep_ff <= '0;
            count_ff <= '0;
         end else begin
            if (cmd.sweep_step) begin
               sweep_ff <= sweep_ff + 1'b1;
            end
            if (cmd.finish_insert && sts.empty) begin
               count_ff <= count_in;
            end
         end
         if (cmd.finish_insert || cmd.finish_clear) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/address_coverage_hash_set.sv =====
// Top level of the address coverage hash set: controller plus datapath.
// Depends on achs_pkg, achs_ctrl, achs_datapath and achs_ram.
`default_nettype none

// Records distinct 32-bit addresses in a 4096-entry open-addressed table with
// linear probing from home slot (address >> 1). Each item gives one result.
// After reset the block sweeps the whole table to zero, during which
// req_ready stays low. An insert probes 1 to 16 slots and then hands
// off its result; the single read port of the slot memory allows one probe
// per cycle. A clear item runs the same sweep and then delivers its result.
// Results sit in an output register, so the next item is taken while a
// finished result still waits for rsp_ready.
module address_coverage_hash_set (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire achs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output achs_pkg::rsp_type      rsp_data
);

   achs_pkg::cmd_type cmd;
   achs_pkg::sts_type sts;

   achs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_kind (req_data.kind),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   achs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // No transfer is taken while the table is being swept.
   a_no_accept_in_sweep : assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> !req_ready)
      else $error("request accepted during clearing sweep");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_new && rsp_data.dropped))
      else $error("result both new and dropped");

   a_count_capped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.distinct_count <= achs_pkg::COUNT_BITS'(achs_pkg::COUNT_CAP)))
      else $error("distinct count above table size");

   a_clear_result : assert property (@(posedge clock) disable iff (reset)
      cmd.finish_clear |=> rsp_valid && (rsp_data.distinct_count == '0))
      else $error("clear result missing or count not zero");

endmodule

`default_nettype wire
